[hw/rtl/me_pkg.sv]
// Shared constants for the modular exponentiation block.
// Used by me_mulmod and modular_exponentiation; no dependencies.
`default_nettype none

package me_pkg;

  localparam int unsigned VAL_W     = 31;
  localparam int unsigned BASE_W    = 32;
  localparam int unsigned EXP_IN_W  = 32;
  localparam int unsigned EXP_WIDTH = 32;
  localparam int unsigned MUL_STEPS = BASE_W;
  localparam int unsigned CNT_W     = $clog2(MUL_STEPS + 1);

  localparam logic [VAL_W-1:0] MODULUS_RESET = VAL_W'(1000000007);
  localparam logic [VAL_W-1:0] VAL_ONE       = VAL_W'(1);
  localparam logic [VAL_W-1:0] VAL_TWO       = VAL_W'(2);

  localparam logic OP_POWER   = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

endpackage

`default_nettype wire

[hw/rtl/me_mulmod.sv]
// Bit-serial interleaved modular multiplier: r = a * b mod m, one bit of b per cycle.
// Requires a < m and m >= 2; depends on me_pkg.
`default_nettype none

module me_mulmod import me_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [VAL_W-1:0]  a_i,
  input  wire logic [BASE_W-1:0] b_i,
  input  wire logic [VAL_W-1:0]  m_i,
  output logic                   done_o,
  output logic [VAL_W-1:0]       r_o
);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [VAL_W-1:0]  a_q;
  logic [BASE_W-1:0] b_q;
  logic [VAL_W-1:0]  r_q, r_d;

  logic [VAL_W+1:0]  t, m1, m2;

  always_comb begin
    t  = {1'b0, r_q, 1'b0} + {2'b00, (b_q[BASE_W-1] ? a_q : '0)};
    m1 = {2'b00, m_i};
    m2 = {1'b0, m_i, 1'b0};
    if (t >= m2) begin
      r_d = VAL_W'(t - m2);
    end else if (t >= m1) begin
      r_d = VAL_W'(t - m1);
    end else begin
      r_d = VAL_W'(t);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MUL_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      r_q <= '0;
    end else if (busy_q) begin
      b_q <= {b_q[BASE_W-2:0], 1'b0};
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule

`default_nettype wire

[hw/rtl/modular_exponentiation.sv]
// Modular exponentiation, right-to-left square and multiply over one shared multiplier.
// Depends on me_pkg and me_mulmod.
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+-------------------------
//   input    | operation_i, base_i, exponent_i           | start && !busy
//   result   | value_o                                   | valid_o, one cycle
//   config   | modulus_i                                 | modulus_we_i
//
// me_mulmod forms each modular product bit-serially, one bit of the multiplier per cycle.
// An item first reduces the base with a product by one, then for each exponent bit
// multiplies the result by the square if the bit is set and squares; the sequence stops
// once the remaining exponent is zero. Modulus below two strobes 0 in the cycle right
// after the accepting edge. Reset loads the modulus 1000000007.
// The result strobe cannot be stalled; a new item may start in the strobe cycle.
`default_nettype none

module modular_exponentiation import me_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                operation_i,
  input  wire logic [BASE_W-1:0]   base_i,
  input  wire logic [EXP_IN_W-1:0] exponent_i,
  input  wire logic                modulus_we_i,
  input  wire logic [VAL_W-1:0]    modulus_i,
  output logic                     valid_o,
  output logic [VAL_W-1:0]         value_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_NEXT = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;

  logic [2:0]           state_q;
  logic [VAL_W-1:0]     mod_q;
  logic                 valid_q;
  logic [VAL_W-1:0]     value_q;
  logic [EXP_WIDTH-1:0] e_q;
  logic [VAL_W-1:0]     acc_q;
  logic [VAL_W-1:0]     sq_q;
  logic                 mul_start_q;
  logic [VAL_W-1:0]     opa_q;
  logic [BASE_W-1:0]    opb_q;
  logic                 mul_done;
  logic [VAL_W-1:0]     mul_r;

  me_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .a_i     (opa_q),
    .b_i     (opb_q),
    .m_i     (mod_q),
    .done_o  (mul_done),
    .r_o     (mul_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mod_q       <= MODULUS_RESET;
      valid_q     <= 1'b0;
      mul_start_q <= 1'b0;
    end else begin
      valid_q     <= 1'b0;
      mul_start_q <= 1'b0;
      if (modulus_we_i) begin
        mod_q <= modulus_i;
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            if (mod_q < VAL_TWO) begin
              valid_q <= 1'b1;
            end else begin
              mul_start_q <= 1'b1;
              state_q     <= S_RED;
            end
          end
        end
        S_RED: begin
          if (mul_done) begin
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (e_q == '0) begin
            valid_q <= 1'b1;
            state_q <= S_IDLE;
          end else if (e_q[0]) begin
            mul_start_q <= 1'b1;
            state_q     <= S_MUL;
          end else begin
            mul_start_q <= 1'b1;
            state_q     <= S_SQ;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            mul_start_q <= 1'b1;
            state_q     <= S_SQ;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            state_q <= S_NEXT;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start) begin
          value_q <= '0;
          acc_q   <= VAL_ONE;
          opa_q   <= VAL_ONE;
          opb_q   <= base_i;
          if (operation_i == OP_INVERSE) begin
            e_q <= EXP_WIDTH'(mod_q - VAL_TWO);
          end else begin
            e_q <= EXP_WIDTH'(exponent_i);
          end
        end
      end
      S_RED: begin
        if (mul_done) begin
          sq_q <= mul_r;
        end
      end
      S_NEXT: begin
        value_q <= acc_q;
        if (e_q[0]) begin
          opa_q <= acc_q;
        end else begin
          opa_q <= sq_q;
        end
        opb_q <= BASE_W'(sq_q);
      end
      S_MUL: begin
        if (mul_done) begin
          acc_q <= mul_r;
          opa_q <= sq_q;
          opb_q <= BASE_W'(sq_q);
        end
      end
      S_SQ: begin
        if (mul_done) begin
          sq_q <= mul_r;
          e_q  <= e_q >> 1;
        end
      end
      default: begin
        value_q <= '0;
      end
    endcase
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign value_o = value_q;

endmodule

`default_nettype wire
